/* rtl/core/signed_int_to_radix_digits_top_assert.svh */
// Assertion macros shared by the converter RTL.
`ifndef SIGNED_INT_TO_RADIX_DIGITS_TOP_ASSERT_SVH
`define SIGNED_INT_TO_RADIX_DIGITS_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SITRD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sitrd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SITRD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sitrd assertion failed");

`endif

/* rtl/core/sitrd_pkg.sv */
`default_nettype none

package sitrd_pkg;

  // Value and radix limits.
  localparam int VALUE_BITS = 32;
  localparam int MAX_RADIX  = 16;
  localparam int RADIX_BITS = 5;
  localparam int CHAR_BITS  = 8;
  localparam int ALPHA_BITS = 64;
  localparam int CFG_BITS   = 64;
  localparam int CFG_IDX_BITS = 2;

  // Digit remainder width and digit stack sizing.
  localparam int REM_BITS   = $clog2(MAX_RADIX);
  localparam int MAX_DIGITS = VALUE_BITS;
  localparam int DEPTH_BITS = $clog2(MAX_DIGITS + 1);
  localparam int SP_BITS    = $clog2(MAX_DIGITS);

  // Divider: quotient bits resolved per cycle and the padded dividend width.
  localparam int DIV_BITS   = 4;
  localparam int DIV_CYCLES = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int PAD_BITS   = DIV_CYCLES * DIV_BITS;
  localparam int CNT_BITS   = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIX     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA_LOW = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA_HI  = 2'd2;

  // Register reset values.
  localparam logic [RADIX_BITS-1:0] RADIX_RESET    = 5'd10;
  localparam logic [ALPHA_BITS-1:0] ALPHA_LO_RESET = 64'h3736353433323130;
  localparam logic [ALPHA_BITS-1:0] ALPHA_HI_RESET = 64'h6665646362613938;

  localparam logic [CHAR_BITS-1:0] MINUS_CHAR = 8'h2D;

  // Divider status seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } sitrd_div_stat_t;

endpackage

`default_nettype wire

/* rtl/core/sitrd_div.sv */
`default_nettype none

// Iterative divider by a small radix: DIV_BITS quotient bits per cycle;
// done pulses for one cycle when the division ends.
module sitrd_div (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [sitrd_pkg::PAD_BITS-1:0] dividend_i,
  input  wire logic [sitrd_pkg::RADIX_BITS-1:0] divisor_i,
  output sitrd_pkg::sitrd_div_stat_t          stat_o,
  output logic      [sitrd_pkg::PAD_BITS-1:0] quotient_o,
  output logic      [sitrd_pkg::REM_BITS-1:0] remainder_o
);
  import sitrd_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic [PAD_BITS-1:0]   num_q, num_d;
  logic [REM_BITS-1:0]   rem_q, rem_d;
  logic [RADIX_BITS-1:0] div_q, div_d;
  logic [REM_BITS-1:0]   rem_step;
  logic [DIV_BITS-1:0]   q_step;

  // Restoring division over DIV_BITS dividend bits, most significant first.
  always_comb begin
    logic [REM_BITS:0] t;
    rem_step = rem_q;
    q_step   = '0;
    for (int j = 0; j < DIV_BITS; j++) begin
      t = {rem_step, num_q[PAD_BITS-1-j]};
      if (t >= div_q) begin
        t = t - (REM_BITS + 1)'(div_q);
        q_step[DIV_BITS-1-j] = 1'b1;
      end
      rem_step = t[REM_BITS-1:0];
    end
  end

  // Sequencing of one division.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      num_d = {num_q[PAD_BITS-DIV_BITS-1:0], q_step};
      rem_d = rem_step;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_BITS'(DIV_CYCLES - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = num_q;
  assign remainder_o  = rem_q;

endmodule

`default_nettype wire

/* rtl/core/signed_int_to_radix_digits_top.sv */
// Channel   Signals                                  Direction
// cfg       cfg_we_i, cfg_idx_i, cfg_wdata_i         in, write only
// in        in_valid_i, in_ready_o, value_i          in
// out       out_valid_o, out_ready_i, character_o,   out
//           last_o
//
// Each digit is one division in the shared divider, resolving 4 quotient
// bits at a time; then a minus sign, if any, and the n digits leave at one
// per cycle while the output is not stalled. in_ready_o is low from
// acceptance until the last character is loaded into the output register;
// a stalled output holds the sequencer. Reset is asynchronous and active low.
`default_nettype none

module signed_int_to_radix_digits_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [sitrd_pkg::CFG_IDX_BITS-1:0] cfg_idx_i,
  input  wire logic [sitrd_pkg::CFG_BITS-1:0]     cfg_wdata_i,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic signed [sitrd_pkg::VALUE_BITS-1:0] value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [sitrd_pkg::CHAR_BITS-1:0]    character_o,
  output logic                                    last_o
);
  import sitrd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e                state_q, state_d;
  logic                  sign_q, sign_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  logic                  oval_q, oval_d;
  logic [CHAR_BITS-1:0]  char_q, char_d;
  logic                  last_q, last_d;

  logic [RADIX_BITS-1:0] radix_q;
  logic [ALPHA_BITS-1:0] alpha_lo_q;
  logic [ALPHA_BITS-1:0] alpha_hi_q;
  logic [RADIX_BITS-1:0] eff_radix;

  logic [REM_BITS-1:0]   stack_q [MAX_DIGITS];
  logic                  push;
  logic [DEPTH_BITS-1:0] top_idx;
  logic [REM_BITS-1:0]   top_digit;
  logic [2*ALPHA_BITS-1:0] alpha;

  logic                  accept;
  logic                  load_ok;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic                  div_start;
  logic [PAD_BITS-1:0]   div_dividend;
  sitrd_div_stat_t       div_stat;
  logic [PAD_BITS-1:0]   div_quot;
  logic [REM_BITS-1:0]   div_rem;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q    <= RADIX_RESET;
      alpha_lo_q <= ALPHA_LO_RESET;
      alpha_hi_q <= ALPHA_HI_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RADIX:     radix_q    <= cfg_wdata_i[RADIX_BITS-1:0];
        CFG_ALPHA_LOW: alpha_lo_q <= cfg_wdata_i;
        CFG_ALPHA_HI:  alpha_hi_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Radix clamped to the supported range.
  always_comb begin
    if (radix_q < RADIX_BITS'(2)) begin
      eff_radix = RADIX_BITS'(2);
    end else if (radix_q > RADIX_BITS'(MAX_RADIX)) begin
      eff_radix = RADIX_BITS'(MAX_RADIX);
    end else begin
      eff_radix = radix_q;
    end
  end

  // Magnitude of the input; the most negative value maps to 2^(VALUE_BITS-1).
  assign raw     = value_i;
  assign mag     = raw[VALUE_BITS-1] ? (VALUE_BITS'(0) - raw) : raw;
  assign accept  = in_valid_i && in_ready_o;
  assign load_ok = !oval_q || out_ready_i;

  // The divider starts on acceptance and again on each nonzero quotient while the digit stack has room.
  assign push         = (state_q == ST_DIV) && div_stat.done;
  assign div_start    = accept || (push && (div_quot != '0) &&
                        (depth_q != DEPTH_BITS'(MAX_DIGITS - 1)));
  assign div_dividend = accept ? PAD_BITS'(mag) : div_quot;

  sitrd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (eff_radix),
    .stat_o      (div_stat),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  // Digit stack: remainders pushed least significant first.
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_q[depth_q[SP_BITS-1:0]] <= div_rem;
    end
  end

  assign top_idx   = depth_q - 1'b1;
  assign top_digit = stack_q[top_idx[SP_BITS-1:0]];
  assign alpha     = {alpha_hi_q, alpha_lo_q};

  // Sequencer and output register.
  always_comb begin
    state_d = state_q;
    sign_d  = sign_q;
    depth_d = depth_q;
    oval_d  = oval_q;
    char_d  = char_q;
    last_d  = last_q;
    if (oval_q && out_ready_i) begin
      oval_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sign_d  = raw[VALUE_BITS-1];
          depth_d = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (push) begin
          depth_d = depth_q + 1'b1;
          if (!div_start) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (load_ok) begin
          oval_d = 1'b1;
          if (sign_q) begin
            char_d = MINUS_CHAR;
            last_d = 1'b0;
            sign_d = 1'b0;
          end else begin
            char_d  = alpha[{top_digit, 3'b000} +: CHAR_BITS];
            last_d  = (depth_q == DEPTH_BITS'(1));
            depth_d = top_idx;
            if (depth_q == DEPTH_BITS'(1)) begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sign_q  <= 1'b0;
      depth_q <= '0;
      oval_q  <= 1'b0;
      char_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sign_q  <= sign_d;
      depth_q <= depth_d;
      oval_q  <= oval_d;
      char_q  <= char_d;
      last_q  <= last_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = oval_q;
  assign character_o = char_q;
  assign last_o      = last_q;

  // Checks on the sequencer and divider handoff.
  `include "signed_int_to_radix_digits_top_assert.svh"

  `SITRD_ASSERT_IMP(a_start_when_free, clk_i, rst_ni, div_start, !div_stat.busy)
  `SITRD_ASSERT_IMP(a_done_in_div, clk_i, rst_ni, div_stat.done, state_q == ST_DIV)
  `SITRD_ASSERT_IMP(a_emit_has_digits, clk_i, rst_ni, state_q == ST_EMIT, depth_q != '0)
  `SITRD_ASSERT_NXT(a_accept_starts, clk_i, rst_ni, accept, div_stat.busy)

endmodule

`default_nettype wire

/* dv/sitrd_text_checker.sv */
module sitrd_text_checker (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [sitrd_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [sitrd_pkg::CFG_BITS-1:0]          cfg_wdata_i,
  input  logic                                    in_valid_i,
  input  logic                                    in_ready_i,
  input  logic signed [sitrd_pkg::VALUE_BITS-1:0] value_i,
  input  logic                                    out_valid_i,
  input  logic                                    out_ready_i,
  input  logic [sitrd_pkg::CHAR_BITS-1:0]         character_i,
  input  logic                                    last_i,
  output int                                      fail_count_o,
  output int                                      pending_o
);

  import sitrd_pkg::*;

  typedef struct packed {
    logic [CHAR_BITS-1:0] glyph;
    logic                 last;
  } text_char_t;

  // Characters still owed by the block, oldest first.
  text_char_t pending_text[$];

  // Shadow copy of the configuration registers.
  logic [RADIX_BITS-1:0] radix_q;
  logic [ALPHA_BITS-1:0] alpha_lo_q;
  logic [ALPHA_BITS-1:0] alpha_hi_q;

  int fail_count = 0;

  assign fail_count_o = fail_count;

  // Only the first few mismatches are printed; all of them are counted.
  task automatic flag_mismatch(input string msg);
    if (fail_count < 10) begin
      $display("%s", msg);
    end
    fail_count++;
  endtask

  // Looks up the character that the alphabet registers hold for one digit.
  function automatic logic [CHAR_BITS-1:0] digit_glyph(input logic [3:0] d);
    if (d[3]) begin
      return alpha_hi_q[8*d[2:0] +: 8];
    end
    return alpha_lo_q[8*d[2:0] +: 8];
  endfunction

  // Appends the text of one value, sign first, then digits from the most
  // significant one down. The most negative value wraps to 2^31 here.
  task automatic queue_value_text(input logic [VALUE_BITS-1:0] raw);
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] base;
    logic [3:0]            digits [0:VALUE_BITS];
    int                    nd;
    text_char_t            tc;

    if (radix_q < 2) begin
      base = 2;
    end else if (radix_q > MAX_RADIX) begin
      base = MAX_RADIX;
    end else begin
      base = VALUE_BITS'(radix_q);
    end
    mag = raw[VALUE_BITS-1] ? (0 - raw) : raw;
    nd = 0;
    do begin
      digits[nd] = 4'(mag % base);
      nd++;
      mag = mag / base;
    end while (mag != 0 && nd < VALUE_BITS + 1);

    if (raw[VALUE_BITS-1]) begin
      tc.glyph = MINUS_CHAR;
      tc.last  = 1'b0;
      pending_text.push_back(tc);
    end
    for (int k = nd - 1; k >= 0; k--) begin
      tc.glyph = digit_glyph(digits[k]);
      tc.last  = (k == 0);
      pending_text.push_back(tc);
    end
  endtask

  // Track register writes, predict on each input transfer and compare on each
  // output transfer.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    text_char_t want;

    if (!rst_ni) begin
      radix_q    = RADIX_RESET;
      alpha_lo_q = ALPHA_LO_RESET;
      alpha_hi_q = ALPHA_HI_RESET;
      pending_text.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_RADIX: begin
            radix_q = cfg_wdata_i[RADIX_BITS-1:0];
          end
          CFG_ALPHA_LOW: begin
            alpha_lo_q = cfg_wdata_i;
          end
          CFG_ALPHA_HI: begin
            alpha_hi_q = cfg_wdata_i;
          end
          default: begin
          end
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        queue_value_text(value_i);
      end

      if (out_valid_i && out_ready_i) begin
        if (pending_text.size() == 0) begin
          flag_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                  character_i, last_i));
        end else begin
          want = pending_text.pop_front();
          if (character_i !== want.glyph) begin
            flag_mismatch($sformatf("character mismatch: expected 0x%02h, got 0x%02h",
                                    want.glyph, character_i));
          end
          if (last_i !== want.last) begin
            flag_mismatch($sformatf("last mismatch on 0x%02h: expected %0b, got %0b",
                                    want.glyph, want.last, last_i));
          end
        end
      end

      pending_o <= pending_text.size();
    end
  end

endmodule

/* dv/tb_top.sv */
module tb_top;

  import sitrd_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam int IDLE_MAX       = 13;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 50;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 30;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                         cfg_we    = 1'b0;
  logic [CFG_IDX_BITS-1:0]      cfg_idx   = CFG_RADIX;
  logic [CFG_BITS-1:0]          cfg_wdata = '0;
  logic                         in_valid  = 1'b0;
  logic signed [VALUE_BITS-1:0] in_value  = '0;
  logic                         out_ready = 1'b0;
  logic                         in_ready;
  logic                         out_valid;
  logic [CHAR_BITS-1:0]         out_char;
  logic                         out_last;

  int fail_count;
  int pending;

  // When clear, both sides run without gaps.
  logic idle_mode = 1'b1;
  int   sink_wait = 0;
  int   sink_draw;
  int   stall_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  signed_int_to_radix_digits_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .value_i    (in_value),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .character_o(out_char),
    .last_o     (out_last)
  );

  sitrd_text_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .value_i     (in_value),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .character_i (out_char),
    .last_i      (out_last),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // The receiver draws a stall length for each character it takes.
  always @(posedge clk_i or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_wait <= 0;
    end else if (out_valid && out_ready) begin
      sink_draw = idle_mode ? $urandom_range(0, IDLE_MAX) : 0;
      sink_wait <= sink_draw;
      out_ready <= (sink_draw == 0);
    end else if (sink_wait != 0) begin
      sink_wait <= sink_wait - 1;
      out_ready <= (sink_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Ends the run when no transfer happens on either channel for too long.
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offers one value, after a random gap when idling, and returns at its transfer edge,
  // with valid still high so that a back-to-back value keeps it up.
  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    int gap;

    gap = idle_mode ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // Holds the sender off until every owed character has come out.
  task automatic wait_for_text();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
  endtask

  // Rewrites all registers on an idle block. Upper radix bits are random
  // since only the low bits are kept; the unused index gets junk too.
  task automatic configure(input logic [RADIX_BITS-1:0] radix,
                           input logic [ALPHA_BITS-1:0] alpha_lo,
                           input logic [ALPHA_BITS-1:0] alpha_hi);
    logic [CFG_BITS-1:0] junk;

    wait_for_text();
    junk = {$urandom, $urandom};
    write_reg(CFG_RADIX, {junk[CFG_BITS-1:RADIX_BITS], radix});
    write_reg(CFG_ALPHA_LOW, alpha_lo);
    write_reg(CFG_ALPHA_HI, alpha_hi);
    write_reg(CFG_UNUSED, {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  // Mix of corner values, small magnitudes, shortened and full-width words.
  function automatic logic [VALUE_BITS-1:0] draw_value();
    logic [VALUE_BITS-1:0] r;
    logic [VALUE_BITS-1:0] corners [6];
    int                    pick;

    corners = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0001};
    r    = $urandom;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        r = corners[$urandom_range(0, 5)];
      end
      1, 2, 3: begin
        r = $urandom_range(0, 300);
        if ($urandom_range(0, 1)) r = 0 - r;
      end
      4, 5: begin
        r = r >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) r = 0 - r;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  initial begin : stimulus
    logic [RADIX_BITS-1:0] phase_radix [RANDOM_PHASES];
    logic [ALPHA_BITS-1:0] lo;
    logic [ALPHA_BITS-1:0] hi;

    phase_radix = '{5'd2, 5'd16, 5'd1, 5'd31, 5'd17, 5'd3, 5'd10, 5'd7};
    phase_radix[RANDOM_PHASES-1] = RADIX_BITS'($urandom_range(0, 31));

    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: decimal with the default alphabet.
    send_value(32'h0);
    send_value(32'h7);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'hEDCB_A988);

    // Hex with an alphabet holding repeats, a minus sign, 0x00 and 0xFF.
    configure(5'd16, 64'h2D41_4141_FF00_7A2D, 64'h0102_0304_0580_2D7F);
    send_value(32'h0);
    send_value(32'h8000_0000);
    send_value(32'h7FFF_FFFF);
    send_value(32'hFEDC_BA98);
    send_value(32'h0123_4567);
    send_value(32'h10);

    // A radix below two acts as binary: longest texts.
    configure(5'd0, ALPHA_LO_RESET, ALPHA_HI_RESET);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'h0);
    send_value(32'h5555_5555);

    // A radix above the maximum acts as sixteen.
    configure(5'd31, ALPHA_LO_RESET, ALPHA_HI_RESET);
    send_value(32'hAAAA_AAAA);
    send_value(32'h8000_0000);
    send_value(32'h0000_000F);

    // Random phases, each on a fresh setting, some without any idling.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      if (p == 6) begin
        lo = ALPHA_LO_RESET;
        hi = ALPHA_HI_RESET;
      end
      configure(phase_radix[p], lo, hi);
      idle_mode <= (p % 3 != 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_value(draw_value());
      end
    end

    wait_for_text();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
